### rtl/core/hbe_pkg.sv
package hbe_pkg;

    localparam int GRID_DIM_DEF   = 256;
    localparam int MAX_RADIUS_DEF = 19;

    typedef enum logic [2:0] {
        MODE_RAISE   = 3'd0,
        MODE_LOWER   = 3'd1,
        MODE_FLATTEN = 3'd2,
        MODE_SMOOTH  = 3'd3,
        MODE_PAINT   = 3'd4,
        MODE_READ    = 3'd5,
        MODE_WRITE   = 3'd6,
        MODE_NONE    = 3'd7
    } mode_t;

    localparam logic [1:0] SHAPE_SQUARE = 2'd1;
    localparam logic [1:0] SHAPE_CIRCLE = 2'd2;

    localparam logic [2:0] REG_MAP_WIDTH   = 3'd0;
    localparam logic [2:0] REG_MAP_DEPTH   = 3'd1;
    localparam logic [2:0] REG_RAISE_STEP  = 3'd2;
    localparam logic [2:0] REG_FLAT_LEVEL  = 3'd3;
    localparam logic [2:0] REG_PAINT_LAYER = 3'd4;

    typedef logic signed [11:0] coord_t;

endpackage

### rtl/core/heightmap_brush_engine.sv
// channel  direction  tdata / tuser
// s_       in         command: shape, center_x, center_z, radius, write_height, write_layer
//                     tuser: mode
// m_       out        result: cells_changed, cell_height, cell_layer; tuser: status
// cfg_     in         register write, index and data, one per cycle
//
// a brush command takes each cell it changes through S_SQ, S_CMP, S_RD, S_WAIT and S_NEXT
// (smooth uses S_NB and S_NBA in place of S_RD and S_WAIT and reads its nine neighbors
// one at a time through the single height memory port); read, write and no-op commands go
// from S_SETUP to S_OUT, read via S_CRD; after reset a clearing pass zeroes the layer memory
// the result register lets a finished result wait while the next request is taken
module heightmap_brush_engine import hbe_pkg::*; #(
    parameter int GRID_DIM   = GRID_DIM_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // shape[1:0] center_x[13:2] center_z[25:14] radius[30:26]
    // write_height[46:31] write_layer[48:47]
    input  logic [55:0] s_tdata,
    // mode[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // cells_changed[10:0] cell_height[26:11] cell_layer[28:27]
    output logic [31:0] m_tdata,
    // status[0]
    output logic        m_tuser,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int CELLS = GRID_DIM * GRID_DIM;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int R2W   = 2 * (RW + 4);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_SETUP = 12'b000000000100,
        S_CRD   = 12'b000000001000,
        S_SQ    = 12'b000000010000,
        S_CMP   = 12'b000000100000,
        S_RD    = 12'b000001000000,
        S_WAIT  = 12'b000010000000,
        S_NB    = 12'b000100000000,
        S_NBA   = 12'b001000000000,
        S_NEXT  = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [8:0]  map_width_reg, map_depth_reg;
    logic [14:0] raise_step_reg;
    logic [15:0] flat_level_reg;
    logic [1:0]  paint_layer_reg;

    mode_t              mode_reg;
    logic [1:0]         shape_reg;
    logic [11:0]        cx_reg, cz_reg;
    logic [RW-1:0]      r_reg;
    logic [15:0]        wh_reg;
    logic [1:0]         wl_reg;
    coord_t             x0_reg, x1_reg, z1_reg, x_reg, z_reg;
    logic signed [1:0]  dx_reg, dz_reg;
    logic signed [20:0] sum_reg;
    logic [31:0]        sqx_reg, sqz_reg;
    logic [R2W-1:0]     r2_reg;
    logic [10:0]        cnt_reg;
    logic [15:0]        oh_reg;
    logic [1:0]         ol_reg;
    logic               st_reg;
    logic [AW-1:0]      clr_reg;

    logic [AW-1:0] raddr;
    logic          h_we, l_we;
    logic [AW-1:0] h_waddr, l_waddr;
    logic [15:0]   h_wdata, h_rdata;
    logic [1:0]    l_wdata, l_rdata;

    function automatic logic [AW-1:0] cell_addr(coord_t xx, coord_t zz);
        cell_addr = AW'($unsigned(zz)) * AW'(GRID_DIM) + AW'($unsigned(xx));
    endfunction

    coord_t w_s, d_s, ix, iz, rr, x0n, x1n, z0n, z1n, nx, nz, nxr, nzr;
    logic   active, empty, outside;
    logic signed [15:0] ddx, ddz;
    logic signed [16:0] hs;
    logic signed [15:0] hnew;
    logic signed [20:0] term, sum_next;
    logic [32:0]        dist2;
    logic [RW+3:0]      r16;

    always_comb begin
        w_s = (map_width_reg < 9'd2) ? 12'sd2 :
              (map_width_reg > GRID_DIM) ? coord_t'(GRID_DIM) : coord_t'({3'b0, map_width_reg});
        d_s = (map_depth_reg < 9'd2) ? 12'sd2 :
              (map_depth_reg > GRID_DIM) ? coord_t'(GRID_DIM) : coord_t'({3'b0, map_depth_reg});
        ix  = coord_t'({4'b0, cx_reg[11:4]});
        iz  = coord_t'({4'b0, cz_reg[11:4]});
        rr  = coord_t'(r_reg);
        x0n = (ix - rr < 12'sd0) ? 12'sd0 : ix - rr;
        x1n = (ix + rr > w_s - 12'sd1) ? w_s - 12'sd1 : ix + rr;
        z0n = (iz - rr < 12'sd0) ? 12'sd0 : iz - rr;
        z1n = (iz + rr > d_s - 12'sd1) ? d_s - 12'sd1 : iz + rr;
        empty   = (x0n > x1n) || (z0n > z1n);
        active  = (shape_reg == SHAPE_SQUARE || shape_reg == SHAPE_CIRCLE) &&
                  !(mode_reg == MODE_PAINT && paint_layer_reg == 2'd0);
        outside = (ix >= w_s) || (iz >= d_s);
        r16     = {r_reg, 4'b0};
        ddx = $signed({4'b0, cx_reg}) - $signed({x_reg, 4'b0});
        ddz = $signed({4'b0, cz_reg}) - $signed({z_reg, 4'b0});
        dist2 = {1'b0, sqx_reg} + {1'b0, sqz_reg};
        nxr = x_reg + coord_t'(dx_reg);
        nzr = z_reg + coord_t'(dz_reg);
        nx  = (nxr < 12'sd0) ? 12'sd0 : ((nxr > w_s - 12'sd1) ? w_s - 12'sd1 : nxr);
        nz  = (nzr < 12'sd0) ? 12'sd0 : ((nzr > d_s - 12'sd1) ? d_s - 12'sd1 : nzr);
        if (mode_reg == MODE_LOWER) begin
            hs = 17'($signed(h_rdata)) - $signed({2'b0, raise_step_reg});
        end else begin
            hs = 17'($signed(h_rdata)) + $signed({2'b0, raise_step_reg});
        end
        hnew = (hs > 17'sd32767) ? 16'sh7fff : ((hs < -17'sd32768) ? 16'sh8000 : hs[15:0]);
        term = (dx_reg == 2'sd0 && dz_reg == 2'sd0) ? 21'($signed(h_rdata)) <<< 3
                                                    : 21'($signed(h_rdata));
        sum_next = sum_reg + term;
    end

    always_comb begin
        raddr   = cell_addr(x_reg, z_reg);
        h_we    = 1'b0;
        h_waddr = cell_addr(x_reg, z_reg);
        h_wdata = hnew;
        l_we    = 1'b0;
        l_waddr = cell_addr(x_reg, z_reg);
        l_wdata = paint_layer_reg;
        case (state_reg)
            S_CLEAR: begin
                l_we    = 1'b1;
                l_waddr = clr_reg;
                l_wdata = 2'd0;
            end
            S_SETUP: begin
                raddr   = cell_addr(ix, iz);
                h_waddr = cell_addr(ix, iz);
                l_waddr = cell_addr(ix, iz);
                h_wdata = wh_reg;
                l_wdata = wl_reg;
                if (mode_reg == MODE_WRITE && !outside) begin
                    h_we = 1'b1;
                    l_we = 1'b1;
                end
            end
            S_WAIT: begin
                case (mode_reg)
                    MODE_RAISE, MODE_LOWER: h_we = 1'b1;
                    MODE_FLATTEN: begin
                        h_we    = 1'b1;
                        h_wdata = flat_level_reg;
                    end
                    MODE_PAINT: l_we = 1'b1;
                    default: ;
                endcase
            end
            S_NB: raddr = cell_addr(nx, nz);
            S_NBA: begin
                h_wdata = sum_next[19:4];
                h_we    = (dx_reg == 2'sd1) && (dz_reg == 2'sd1);
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == AW'(CELLS - 1)) state_next = S_IDLE;
            S_IDLE:  if (s_tvalid) state_next = S_SETUP;
            S_SETUP: begin
                case (mode_reg)
                    MODE_RAISE, MODE_LOWER, MODE_FLATTEN, MODE_SMOOTH, MODE_PAINT:
                        state_next = (active && !empty) ? S_SQ : S_OUT;
                    MODE_READ: state_next = outside ? S_OUT : S_CRD;
                    default: state_next = S_OUT;
                endcase
            end
            S_CRD: state_next = S_OUT;
            S_SQ:  state_next = S_CMP;
            S_CMP: begin
                if (shape_reg == SHAPE_CIRCLE && dist2 > 33'(r2_reg)) begin
                    state_next = S_NEXT;
                end else if (mode_reg == MODE_SMOOTH) begin
                    state_next = S_NB;
                end else begin
                    state_next = S_RD;
                end
            end
            S_RD:   state_next = S_WAIT;
            S_WAIT: state_next = S_NEXT;
            S_NB:   state_next = S_NBA;
            S_NBA:  state_next = h_we ? S_NEXT : S_NB;
            S_NEXT: begin
                if (x_reg == x1_reg && z_reg == z1_reg) state_next = S_OUT;
                else state_next = S_SQ;
            end
            S_OUT: if (!m_tvalid || m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            m_tvalid        <= 1'b0;
            map_width_reg   <= 9'd256;
            map_depth_reg   <= 9'd256;
            raise_step_reg  <= 15'd21;
            flat_level_reg  <= 16'd1;
            paint_layer_reg <= 2'd1;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + AW'(1);
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MAP_WIDTH:   map_width_reg   <= cfg_wdata[8:0];
                    REG_MAP_DEPTH:   map_depth_reg   <= cfg_wdata[8:0];
                    REG_RAISE_STEP:  raise_step_reg  <= cfg_wdata[14:0];
                    REG_FLAT_LEVEL:  flat_level_reg  <= cfg_wdata;
                    REG_PAINT_LAYER: paint_layer_reg <= cfg_wdata[1:0];
                    default: ;
                endcase
            end
            if (state_reg == S_OUT && (!m_tvalid || m_tready)) begin
                m_tvalid <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                mode_reg  <= mode_t'(s_tuser);
                shape_reg <= s_tdata[1:0];
                cx_reg    <= s_tdata[13:2];
                cz_reg    <= s_tdata[25:14];
                r_reg     <= (s_tdata[30:26] > MAX_RADIUS) ? RW'(MAX_RADIUS)
                                                           : RW'(s_tdata[30:26]);
                wh_reg    <= s_tdata[46:31];
                wl_reg    <= s_tdata[48:47];
                cnt_reg   <= '0;
                oh_reg    <= '0;
                ol_reg    <= '0;
                st_reg    <= 1'b0;
            end
            S_SETUP: begin
                x0_reg <= x0n;
                x1_reg <= x1n;
                z1_reg <= z1n;
                x_reg  <= x0n;
                z_reg  <= z0n;
                r2_reg <= R2W'(r16 * r16);
                if ((mode_reg == MODE_READ || mode_reg == MODE_WRITE) && outside) begin
                    st_reg <= 1'b1;
                end
                if (mode_reg == MODE_WRITE && !outside) cnt_reg <= 11'd1;
            end
            S_CRD: begin
                oh_reg <= h_rdata;
                ol_reg <= l_rdata;
            end
            S_SQ: begin
                sqx_reg <= 32'(ddx * ddx);
                sqz_reg <= 32'(ddz * ddz);
            end
            S_CMP: begin
                dx_reg  <= -2'sd1;
                dz_reg  <= -2'sd1;
                sum_reg <= '0;
            end
            S_WAIT: cnt_reg <= cnt_reg + 11'd1;
            S_NBA: begin
                sum_reg <= sum_next;
                if (dx_reg == 2'sd1) begin
                    dx_reg <= -2'sd1;
                    dz_reg <= dz_reg + 2'sd1;
                end else begin
                    dx_reg <= dx_reg + 2'sd1;
                end
                if (h_we) cnt_reg <= cnt_reg + 11'd1;
            end
            S_NEXT: begin
                if (x_reg == x1_reg) begin
                    x_reg <= x0_reg;
                    z_reg <= z_reg + 12'sd1;
                end else begin
                    x_reg <= x_reg + 12'sd1;
                end
            end
            S_OUT: begin
                if (!m_tvalid || m_tready) begin
                    m_tdata <= {3'b0, ol_reg, oh_reg, cnt_reg};
                    m_tuser <= st_reg;
                end
            end
            default: ;
        endcase
    end

    hbe_ram #(.WIDTH(16), .DEPTH(CELLS)) u_height_ram (
        .aclk  (aclk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (raddr),
        .rdata (h_rdata)
    );

    hbe_ram #(.WIDTH(2), .DEPTH(CELLS)) u_layer_ram (
        .aclk  (aclk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (raddr),
        .rdata (l_rdata)
    );

`ifndef SYNTHESIS
    a_busy_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !s_tready)
        else $error("request taken during clearing pass");
    a_out_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("pending result lost");
    a_nb_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_NB |=> state_reg == S_NBA)
        else $error("neighbor read not followed by accumulate");
`endif

endmodule

### rtl/core/hbe_ram.sv
module hbe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
